// ===== rtl/bmhs_pkg.sv =====
`timescale 1ns / 1ps

package bmhs_pkg;

    localparam int SAMPLE_WIDTH    = 16;
    localparam int ALPHA_FRAC_BITS = 16;
    localparam int ALPHA_W         = ALPHA_FRAC_BITS + 1;
    localparam int CFG_DATA_W      = (ALPHA_W > SAMPLE_WIDTH) ? ALPHA_W : SAMPLE_WIDTH;
    localparam int CFG_IDX_W       = 3;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(1) << ALPHA_FRAC_BITS;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(ALPHA_ONE >> 2);

    localparam logic [SAMPLE_WIDTH-1:0] UP_SAFE_RESET     = SAMPLE_WIDTH'(6600);
    localparam logic [SAMPLE_WIDTH-1:0] UP_CRUISE_RESET   = SAMPLE_WIDTH'(7100);
    localparam logic [SAMPLE_WIDTH-1:0] UP_FULL_RESET     = SAMPLE_WIDTH'(7500);
    localparam logic [SAMPLE_WIDTH-1:0] DOWN_SAFE_RESET   = SAMPLE_WIDTH'(6500);
    localparam logic [SAMPLE_WIDTH-1:0] DOWN_CRUISE_RESET = SAMPLE_WIDTH'(7000);
    localparam logic [SAMPLE_WIDTH-1:0] DOWN_FULL_RESET   = SAMPLE_WIDTH'(7400);

    typedef enum logic [1:0] {
        MODE_CRITICAL = 2'd0,
        MODE_SAFE     = 2'd1,
        MODE_CRUISE   = 2'd2,
        MODE_FULL     = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA       = 3'd0,
        CFG_UP_SAFE     = 3'd1,
        CFG_UP_CRUISE   = 3'd2,
        CFG_UP_FULL     = 3'd3,
        CFG_DOWN_SAFE   = 3'd4,
        CFG_DOWN_CRUISE = 3'd5,
        CFG_DOWN_FULL   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] up_safe;
        logic [SAMPLE_WIDTH-1:0] up_cruise;
        logic [SAMPLE_WIDTH-1:0] up_full;
        logic [SAMPLE_WIDTH-1:0] down_safe;
        logic [SAMPLE_WIDTH-1:0] down_cruise;
        logic [SAMPLE_WIDTH-1:0] down_full;
    } t_levels;

endpackage

// ===== rtl/battery_mode_hysteresis_select.sv =====
`timescale 1ns / 1ps

// Battery voltage smoother and power mode selector.
// Input channel: i_in_valid / o_in_stall carry one raw voltage sample per
// transfer. Output channel: o_out_valid / i_out_stall carry one result per
// sample: the power mode, the smoothed voltage and a flag that is set when
// this sample changed the mode.
// A sample passes the input register and then the result register.
// Throughput is one sample per cycle while the receiver does not stall;
// the whole filter update (one 17 by 17 bit multiply and an add) and the
// six level compares sit between the input register and the result
// register, so the running average is ready for the next sample at once.
// Reset clears the average to zero, the mode to critical and the registers
// to their default weight of 0.25 and default levels, and empties both
// stages. When the receiver stalls, the result is held; if the input
// register is empty, one more sample is still taken into it, after which o_in_stall rises.
// Configuration writes are taken in any cycle and should be made while the
// block is idle.
module battery_mode_hysteresis_select
    import bmhs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [SAMPLE_WIDTH-1:0] i_sample_voltage,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [1:0]              o_power_mode,
    output logic [SAMPLE_WIDTH-1:0] o_filtered_voltage,
    output logic                    o_mode_changed
);

    logic [ALPHA_W-1:0]      alpha;
    t_levels                 levels;
    logic                    r_in_valid;
    logic [SAMPLE_WIDTH-1:0] r_sample;
    logic [SAMPLE_WIDTH-1:0] r_avg;
    t_mode                   r_mode;
    logic                    r_out_valid;
    logic [1:0]              r_out_mode;
    logic [SAMPLE_WIDTH-1:0] r_out_avg;
    logic                    r_out_changed;
    logic [SAMPLE_WIDTH-1:0] n_avg;
    t_mode                   n_mode;
    logic                    advance;

    bmhs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_alpha     (alpha),
        .o_levels    (levels)
    );

    bmhs_filter u_filter (
        .i_sample  (r_sample),
        .i_old_avg (r_avg),
        .i_alpha   (alpha),
        .o_new_avg (n_avg)
    );

    bmhs_mode_select u_mode (
        .i_new_avg (n_avg),
        .i_old_avg (r_avg),
        .i_mode    (r_mode),
        .i_levels  (levels),
        .o_mode    (n_mode)
    );

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_sample <= i_sample_voltage;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg       <= '0;
            r_mode      <= MODE_CRITICAL;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_avg       <= n_avg;
            r_mode      <= n_mode;
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_mode    <= n_mode;
            r_out_avg     <= n_avg;
            r_out_changed <= (n_mode != r_mode);
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_power_mode       = r_out_mode;
    assign o_filtered_voltage = r_out_avg;
    assign o_mode_changed     = r_out_changed;

endmodule

// ===== rtl/bmhs_cfg_regs.sv =====
`timescale 1ns / 1ps

module bmhs_cfg_regs
    import bmhs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output logic [ALPHA_W-1:0]    o_alpha,
    output t_levels               o_levels
);

    logic [ALPHA_W-1:0]      r_alpha;
    t_levels                 r_levels;
    logic [ALPHA_W-1:0]      wdata_alpha;
    logic [SAMPLE_WIDTH-1:0] wdata_level;

    // A weight above one is saturated on the way in.
    always_comb begin
        wdata_alpha = i_cfg_wdata[ALPHA_W-1:0];
        if (wdata_alpha > ALPHA_ONE) begin
            wdata_alpha = ALPHA_ONE;
        end
        wdata_level = i_cfg_wdata[SAMPLE_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha              <= ALPHA_RESET;
            r_levels.up_safe     <= UP_SAFE_RESET;
            r_levels.up_cruise   <= UP_CRUISE_RESET;
            r_levels.up_full     <= UP_FULL_RESET;
            r_levels.down_safe   <= DOWN_SAFE_RESET;
            r_levels.down_cruise <= DOWN_CRUISE_RESET;
            r_levels.down_full   <= DOWN_FULL_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ALPHA:       r_alpha              <= wdata_alpha;
                CFG_UP_SAFE:     r_levels.up_safe     <= wdata_level;
                CFG_UP_CRUISE:   r_levels.up_cruise   <= wdata_level;
                CFG_UP_FULL:     r_levels.up_full     <= wdata_level;
                CFG_DOWN_SAFE:   r_levels.down_safe   <= wdata_level;
                CFG_DOWN_CRUISE: r_levels.down_cruise <= wdata_level;
                CFG_DOWN_FULL:   r_levels.down_full   <= wdata_level;
                default: begin
                end
            endcase
        end
    end

    assign o_alpha  = r_alpha;
    assign o_levels = r_levels;

endmodule

// ===== rtl/bmhs_filter.sv =====
`timescale 1ns / 1ps

module bmhs_filter
    import bmhs_pkg::*;
(
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  logic [SAMPLE_WIDTH-1:0] i_old_avg,
    input  logic [ALPHA_W-1:0]      i_alpha,
    output logic [SAMPLE_WIDTH-1:0] o_new_avg
);

    localparam int DIFF_W = SAMPLE_WIDTH + 1;
    localparam int PROD_W = ALPHA_W + 1 + DIFF_W;
    localparam int ACC_W  = SAMPLE_WIDTH + ALPHA_FRAC_BITS + 3;

    logic signed [DIFF_W-1:0]  diff;
    logic signed [ALPHA_W:0]   alpha_s;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   acc;

    // old + a * (x - old), rounded half up: one multiplier instead of two.
    always_comb begin
        diff    = $signed({1'b0, i_sample}) - $signed({1'b0, i_old_avg});
        alpha_s = $signed({1'b0, i_alpha});
        prod    = PROD_W'(alpha_s) * PROD_W'(diff);
        acc     = ($signed(ACC_W'({1'b0, i_old_avg})) <<< ALPHA_FRAC_BITS)
                + ACC_W'(prod)
                + $signed(ACC_W'(1) <<< (ALPHA_FRAC_BITS - 1));
        o_new_avg = acc[ALPHA_FRAC_BITS +: SAMPLE_WIDTH];
    end

endmodule

// ===== rtl/bmhs_mode_select.sv =====
`timescale 1ns / 1ps

module bmhs_mode_select
    import bmhs_pkg::*;
(
    input  logic [SAMPLE_WIDTH-1:0] i_new_avg,
    input  logic [SAMPLE_WIDTH-1:0] i_old_avg,
    input  t_mode                   i_mode,
    input  t_levels                 i_levels,
    output t_mode                   o_mode
);

    logic rising;

    // An unchanged average counts as falling, so the down levels apply.
    always_comb begin
        rising = i_new_avg > i_old_avg;
        o_mode = i_mode;
        if (rising) begin
            if (i_new_avg > i_levels.up_full) begin
                o_mode = MODE_FULL;
            end else if (i_new_avg > i_levels.up_cruise) begin
                o_mode = MODE_CRUISE;
            end else if (i_new_avg > i_levels.up_safe) begin
                o_mode = MODE_SAFE;
            end
        end else begin
            if (i_new_avg < i_levels.down_safe) begin
                o_mode = MODE_CRITICAL;
            end else if (i_new_avg < i_levels.down_cruise) begin
                o_mode = MODE_SAFE;
            end else if (i_new_avg < i_levels.down_full) begin
                o_mode = MODE_CRUISE;
            end
        end
    end

endmodule

// ===== rtl/bmhs_checker.sv =====
`timescale 1ns / 1ps

module bmhs_checker
    import bmhs_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic [1:0]              o_power_mode,
    input logic [SAMPLE_WIDTH-1:0] o_filtered_voltage,
    input logic                    o_mode_changed
);

    // A stalled result stays offered.
    a_out_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result does not change.
    a_out_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_power_mode)
            && $stable(o_filtered_voltage) && $stable(o_mode_changed))
        else $error("result changed while stalled");

    // The input side only stalls when a result is waiting on the output.
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with an empty output");

    // An accepted sample is followed by a valid result, past the input and result registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> ##1 o_out_valid)
        else $error("accepted sample did not produce a result in time");

endmodule

bind battery_mode_hysteresis_select bmhs_checker u_bmhs_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_stall         (o_in_stall),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_power_mode       (o_power_mode),
    .o_filtered_voltage (o_filtered_voltage),
    .o_mode_changed     (o_mode_changed)
);
